// File: rtl/gb3_pkg.sv
// Shared constants, types and the 3x3 binomial kernel for the blur block.
// No dependencies; every other source file except gb3_ram imports this package.
package gb3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ADDR_W       = $clog2(MAX_WIDTH);
   localparam int POS_W        = $clog2(HEIGHT_LIMIT) > ADDR_W ? $clog2(HEIGHT_LIMIT) : ADDR_W;
   localparam int CNT_W        = 11;
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 3 * CHAN_W;
   localparam int SUM_W        = CHAN_W + 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 11;

   localparam logic [CNT_W-1:0] DEF_WIDTH  = CNT_W'(640);
   localparam logic [CNT_W-1:0] DEF_HEIGHT = CNT_W'(480);

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic              is_pix;
      logic              emit;
      logic              border;
      logic              frame_end;
      logic              flush_older;
      logic              fwd;
      logic [ADDR_W-1:0] addr;
   } s1_ctl_type;

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) r = CNT_W'(1);
      else if (v > lim) r = lim;
      return r;
   endfunction

   // columns: w0..w2 oldest, w3..w5 middle, c0..c2 newest; top to bottom
   function automatic logic [PIX_W-1:0] blur3x3(
      input logic [PIX_W-1:0] w0, input logic [PIX_W-1:0] w1, input logic [PIX_W-1:0] w2,
      input logic [PIX_W-1:0] w3, input logic [PIX_W-1:0] w4, input logic [PIX_W-1:0] w5,
      input logic [PIX_W-1:0] c0, input logic [PIX_W-1:0] c1, input logic [PIX_W-1:0] c2);
      logic [SUM_W-1:0] sum;
      logic [PIX_W-1:0] res;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         sum = SUM_W'(w0[CHAN_W*ch +: CHAN_W])
             + SUM_W'({w1[CHAN_W*ch +: CHAN_W], 1'b0})
             + SUM_W'(w2[CHAN_W*ch +: CHAN_W])
             + SUM_W'({w3[CHAN_W*ch +: CHAN_W], 1'b0})
             + SUM_W'({w4[CHAN_W*ch +: CHAN_W], 2'b00})
             + SUM_W'({w5[CHAN_W*ch +: CHAN_W], 1'b0})
             + SUM_W'(c0[CHAN_W*ch +: CHAN_W])
             + SUM_W'({c1[CHAN_W*ch +: CHAN_W], 1'b0})
             + SUM_W'(c2[CHAN_W*ch +: CHAN_W]);
         res[CHAN_W*ch +: CHAN_W] = sum[SUM_W-1:4];
      end
      return res;
   endfunction

endpackage

// File: rtl/gb3_if.sv
// Valid/ready channel interfaces for pixel requests and blurred responses.
// Depends on gb3_pkg for field widths.
interface gb3_req_if import gb3_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [CHAN_W-1:0] in_blue;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_red;

   modport source (output valid, mode, in_blue, in_green, in_red, input ready);
   modport sink   (input valid, mode, in_blue, in_green, in_red, output ready);
endinterface

interface gb3_rsp_if import gb3_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_blue;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_red;
   logic              frame_end;

   modport source (output valid, out_blue, out_green, out_red, frame_end, input ready);
   modport sink   (input valid, out_blue, out_green, out_red, frame_end, output ready);
endinterface

// File: rtl/gaussian_blur_3x3_rgb_top.sv
// Streaming 3x3 Gaussian blur over BGR pixels with two line memories.
// Depends on gb3_pkg, gb3_req_if, gb3_rsp_if and gb3_ram.
//
//   channel   direction  handshake          contents
//   req_ch    in         valid/ready        mode, in_blue, in_green, in_red
//   rsp_ch    out        valid/ready        out_blue, out_green, out_red, frame_end
//   csr_*     in         write enable only  csr_index, csr_wdata
//
// One transaction per clock sustained while rsp_ch takes results; a request
// passes the line memory read, then the filter into the output register.
// Read-modify-write of the line memories forwards between back-to-back requests to the same column.
// Reset is synchronous and clears positions, counts and window; memories keep data.
// req_ch.ready drops only while a result waits in the output register and another
// result is held behind it.
module gaussian_blur_3x3_rgb_top import gb3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   gb3_req_if.sink               req_ch,
   gb3_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic [CNT_W-1:0]  eff_w_ff, eff_w_in, eff_h_ff, eff_h_in;
   logic [POS_W-1:0]  in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [POS_W-1:0]  out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [CNT_W-1:0]  pend_ff, pend_in;
   logic [POS_W-1:0]  w_last, h_last;
   logic [CNT_W-1:0]  w_p1, pend_inc;
   logic              accept, is_flush, flush_emit, pix_emit, emit;
   logic [ADDR_W-1:0] raddr;

   s1_ctl_type        s1_ctl_ff, s1_ctl_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_pix_ff, s1_pix_in;
   logic [PIX_W-1:0]  fwd_older_ff, fwd_older_in, fwd_newer_ff, fwd_newer_in;
   logic [PIX_W-1:0]  rd_older, rd_newer, cur_older, cur_newer, blurred, result;
   logic              advance, wr_en;

   logic [PIX_W-1:0]  win_ff [6];
   logic [PIX_W-1:0]  win_in [6];

   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  out_pix_ff, out_pix_in;
   logic              out_end_ff, out_end_in;

   assign w_last   = POS_W'(eff_w_ff - CNT_W'(1));
   assign h_last   = POS_W'(eff_h_ff - CNT_W'(1));
   assign w_p1     = eff_w_ff + CNT_W'(1);
   assign pend_inc = pend_ff + CNT_W'(1);

   assign advance      = s1_valid_ff && (!s1_ctl_ff.emit || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_flush     = (req_ch.mode == MODE_FLUSH);
   assign flush_emit   = (in_row_ff == '0) && (in_col_ff == '0) && (pend_ff != '0);
   assign pix_emit     = pend_inc > w_p1;
   assign emit         = is_flush ? flush_emit : pix_emit;

   always_comb begin
      if (!is_flush) raddr = ADDR_W'(in_col_ff);
      else if (pend_ff == w_p1) raddr = ADDR_W'(w_last);
      else raddr = ADDR_W'(out_col_ff);
   end

   // input side: frame size, positions and counts
   always_comb begin
      eff_w_in   = eff_w_ff;
      eff_h_in   = eff_h_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;
      if (csr_we && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT)) begin
         if (csr_index == REG_FRAME_WIDTH)
            eff_w_in = clamp_dim(CNT_W'(csr_wdata), CNT_W'(MAX_WIDTH));
         else
            eff_h_in = clamp_dim(CNT_W'(csr_wdata), CNT_W'(HEIGHT_LIMIT));
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = '0;
      end else if (accept) begin
         if (!is_flush) begin
            if (in_col_ff == w_last) begin
               in_col_in = '0;
               in_row_in = (in_row_ff == h_last) ? '0 : in_row_ff + POS_W'(1);
            end else begin
               in_col_in = in_col_ff + POS_W'(1);
            end
            pend_in = pix_emit ? w_p1 : pend_inc;
         end else if (flush_emit) begin
            pend_in = pend_ff - CNT_W'(1);
         end
         if (emit) begin
            if (out_col_ff == w_last) begin
               out_col_in = '0;
               out_row_in = (out_row_ff == h_last) ? '0 : out_row_ff + POS_W'(1);
            end else begin
               out_col_in = out_col_ff + POS_W'(1);
            end
         end
      end
   end

   // stage 1 capture
   always_comb begin
      s1_ctl_in    = s1_ctl_ff;
      s1_pix_in    = s1_pix_ff;
      fwd_older_in = fwd_older_ff;
      fwd_newer_in = fwd_newer_ff;
      if (accept) s1_valid_in = 1'b1;
      else if (advance) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_ctl_in.is_pix      = !is_flush;
         s1_ctl_in.emit        = emit;
         s1_ctl_in.border      = (out_row_ff == '0) || (out_row_ff == h_last)
                              || (out_col_ff == '0) || (out_col_ff == w_last);
         s1_ctl_in.frame_end   = (out_row_ff == h_last) && (out_col_ff == w_last);
         s1_ctl_in.flush_older = (pend_ff == w_p1);
         s1_ctl_in.fwd         = s1_valid_ff && s1_ctl_ff.is_pix && (s1_ctl_ff.addr == raddr);
         s1_ctl_in.addr        = raddr;
         s1_pix_in             = {req_ch.in_red, req_ch.in_green, req_ch.in_blue};
         fwd_older_in          = cur_newer;
         fwd_newer_in          = s1_pix_ff;
      end
   end

   gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
      .clock (clock),
      .we    (wr_en),
      .waddr (s1_ctl_ff.addr),
      .wdata (cur_newer),
      .re    (accept),
      .raddr (raddr),
      .rdata (rd_older)
   );

   gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
      .clock (clock),
      .we    (wr_en),
      .waddr (s1_ctl_ff.addr),
      .wdata (s1_pix_ff),
      .re    (accept),
      .raddr (raddr),
      .rdata (rd_newer)
   );

   assign wr_en     = advance && s1_ctl_ff.is_pix;
   assign cur_older = s1_ctl_ff.fwd ? fwd_older_ff : rd_older;
   assign cur_newer = s1_ctl_ff.fwd ? fwd_newer_ff : rd_newer;
   assign blurred   = blur3x3(win_ff[0], win_ff[1], win_ff[2], win_ff[3], win_ff[4],
                              win_ff[5], cur_older, cur_newer, s1_pix_ff);

   always_comb begin
      if (!s1_ctl_ff.is_pix) result = s1_ctl_ff.flush_older ? cur_older : cur_newer;
      else if (s1_ctl_ff.border) result = win_ff[4];
      else result = blurred;
   end

   always_comb begin
      win_in = win_ff;
      if (wr_en) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = cur_older;
         win_in[4] = cur_newer;
         win_in[5] = s1_pix_ff;
      end
   end

   always_comb begin
      out_pix_in = out_pix_ff;
      out_end_in = out_end_ff;
      if (advance && s1_ctl_ff.emit) begin
         out_valid_in = 1'b1;
         out_pix_in   = result;
         out_end_in   = s1_ctl_ff.frame_end;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff     <= DEF_WIDTH;
         eff_h_ff     <= DEF_HEIGHT;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         pend_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         eff_w_ff     <= eff_w_in;
         eff_h_ff     <= eff_h_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff    <= s1_ctl_in;
      s1_pix_ff    <= s1_pix_in;
      fwd_older_ff <= fwd_older_in;
      fwd_newer_ff <= fwd_newer_in;
      out_pix_ff   <= out_pix_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_blue  = out_pix_ff[CHAN_W-1:0];
   assign rsp_ch.out_green = out_pix_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_ch.out_red   = out_pix_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_ch.frame_end = out_end_ff;
endmodule

// File: rtl/gb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/gb3_checker.sv
// Port-level checks for the blur top level, attached by bind.
// Depends on gb3_pkg and gaussian_blur_3x3_rgb_top.
module gb3_checker import gb3_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_blue,
   input logic [CHAN_W-1:0] rsp_green,
   input logic [CHAN_W-1:0] rsp_red,
   input logic              rsp_end
);
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blue) && $stable(rsp_green)
                                  && $stable(rsp_red) && $stable(rsp_end))
      else $error("stalled rsp transaction changed");

   a_backpressure_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without rsp stall");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp appeared without req transaction two cycles earlier");
endmodule

bind gaussian_blur_3x3_rgb_top gb3_checker u_gb3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_blue  (rsp_ch.out_blue),
   .rsp_green (rsp_ch.out_green),
   .rsp_red   (rsp_ch.out_red),
   .rsp_end   (rsp_ch.frame_end)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_blur_3x3_rgb_top: frames of random BGR pixels and
// flush ticks, checked against a cycle-free blur predictor. Needs gb3_pkg, gb3_req_if,
// gb3_rsp_if and the blur RTL.
module testbench;
   import gb3_pkg::*;

   typedef struct packed {
      logic              mode;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              frame_end;
   } blurred_type;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_GAP       = 18;
   localparam int TAP [3]       = '{1, 2, 1};

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = CSR_IDX_W'(3);

   localparam int N_PHASES      = 8;
   localparam int PHASE_PIXELS  = 40;
   localparam int PH_WIDTH [N_PHASES]  = '{1, 0, 3, 5, 2, 7, 16, 6};
   localparam int PH_HEIGHT [N_PHASES] = '{1, 0, 2, 4, 7, 5, 3, 2047};

   localparam logic [PIX_W-1:0] OPENING_FRAME [12] = '{
      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h01FE80,
      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h55AA00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gb3_req_if req_ch ();
   gb3_rsp_if rsp_ch ();

   gaussian_blur_3x3_rgb_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pixel_req_type pixel_stream [$];
   blurred_type   blurred_due [$];
   pixel_req_type held_req;

   logic [CNT_W-1:0] cfg_width  = DEF_WIDTH;
   logic [CNT_W-1:0] cfg_height = DEF_HEIGHT;
   logic [PIX_W-1:0] older_row [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0] newer_row [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0] window [6] = '{default: '0};
   int in_row = 0, in_col = 0, out_row = 0, out_col = 0, backlog = 0;

   int  gen_pos = 0;
   bit  calm = 1'b0;
   int  send_gap = 0, stall_left = 0;
   int  errors = 0, cycles = 0;
   int  pixels_sent = 0, flushes_sent = 0, results_checked = 0, settings_used = 0;

   function automatic int active_size(input logic [CNT_W-1:0] v, input int lim);
      if (v == '0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] rand_channel();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_req_type flush_item();
      pixel_req_type item;
      item.mode  = MODE_FLUSH;
      item.blue  = rand_channel();
      item.green = rand_channel();
      item.red   = rand_channel();
      return item;
   endfunction

   task automatic queue_result(input logic [PIX_W-1:0] pix, input int w, input int h);
      blurred_type res;
      res.blue      = pix[CHAN_W*0 +: CHAN_W];
      res.green     = pix[CHAN_W*1 +: CHAN_W];
      res.red       = pix[CHAN_W*2 +: CHAN_W];
      res.frame_end = (out_row == h - 1 && out_col == w - 1);
      blurred_due.push_back(res);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
   endtask

   // one accepted request: a pixel advances the line stores and window; queue any result due
   task automatic blur_next_pixel(input pixel_req_type item);
      int w, h, c, ch, r, sum;
      logic [PIX_W-1:0] cur [3];
      logic [PIX_W-1:0] pix;
      logic on_border;
      w = active_size(cfg_width, MAX_WIDTH);
      h = active_size(cfg_height, HEIGHT_LIMIT);
      if (item.mode == MODE_FLUSH) begin
         if (in_row == 0 && in_col == 0 && backlog != 0) begin
            pix = (backlog == w + 1) ? older_row[w-1] : newer_row[out_col];
            backlog--;
            queue_result(pix, w, h);
         end
      end else begin
         c = in_col;
         cur[0] = older_row[c];
         cur[1] = newer_row[c];
         cur[2] = {item.red, item.green, item.blue};
         older_row[c] = cur[1];
         newer_row[c] = cur[2];
         on_border = (out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1);
         pix = window[4];
         if (!on_border) begin
            for (ch = 0; ch < 3; ch++) begin
               sum = 0;
               for (r = 0; r < 3; r++) begin
                  sum += TAP[r] * (TAP[0] * window[r][CHAN_W*ch +: CHAN_W]
                                 + TAP[1] * window[3+r][CHAN_W*ch +: CHAN_W]
                                 + TAP[2] * cur[r][CHAN_W*ch +: CHAN_W]);
               end
               pix[CHAN_W*ch +: CHAN_W] = CHAN_W'(sum / 16);
            end
         end
         for (r = 0; r < 3; r++) begin
            window[r]   = window[3+r];
            window[3+r] = cur[r];
         end
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
         backlog++;
         if (backlog > w + 1) begin
            backlog = w + 1;
            queue_result(pix, w, h);
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
         if (idx == REG_FRAME_WIDTH) cfg_width = CNT_W'(value);
         else cfg_height = CNT_W'(value);
         in_row = 0;
         in_col = 0;
         out_row = 0;
         out_col = 0;
         backlog = 0;
         gen_pos = 0;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pixel_stream.size() != 0 || req_ch.valid || blurred_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_frame(input int w, input int h);
      wait_drained();
      write_csr(REG_FRAME_WIDTH, w);
      write_csr(REG_FRAME_HEIGHT, h);
      settings_used++;
   endtask

   // raster pixels with stray flush ticks; after each frame drain all, part or none of the tail
   task automatic queue_pixels(input int count);
      int w, h, done, extra;
      pixel_req_type item;
      w = active_size(cfg_width, MAX_WIDTH);
      h = active_size(cfg_height, HEIGHT_LIMIT);
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 11) == 0) pixel_stream.push_back(flush_item());
         item.mode  = MODE_PIXEL;
         item.blue  = rand_channel();
         item.green = rand_channel();
         item.red   = rand_channel();
         pixel_stream.push_back(item);
         done++;
         gen_pos++;
         if (gen_pos == w * h) begin
            gen_pos = 0;
            case ($urandom_range(0, 3))
               0, 1: extra = w + 1 + $urandom_range(0, 2);
               2: extra = $urandom_range(1, w);
               default: extra = 0;
            endcase
            repeat (extra) pixel_stream.push_back(flush_item());
         end
      end
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // request driver: hold valid until the transaction completes, idle in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            blur_next_pixel(held_req);
            if (held_req.mode == MODE_FLUSH) flushes_sent++;
            else pixels_sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pixel_stream.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(1, MAX_GAP) - 1;
            req_ch.valid <= 1'b0;
         end else begin
            held_req = pixel_stream.pop_front();
            req_ch.valid    <= 1'b1;
            req_ch.mode     <= held_req.mode;
            req_ch.in_blue  <= held_req.blue;
            req_ch.in_green <= held_req.green;
            req_ch.in_red   <= held_req.red;
         end
      end
   end

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   // response monitor: stall ready at random, compare each transaction with the oldest result due
   always @(posedge clock) begin
      blurred_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (blurred_due.size() == 0) begin
               errors++;
               $display("%0t: expected no result, actual b=%0h g=%0h r=%0h end=%0b", $time,
                        rsp_ch.out_blue, rsp_ch.out_green, rsp_ch.out_red, rsp_ch.frame_end);
            end else begin
               want = blurred_due.pop_front();
               check_field("out_blue", want.blue, rsp_ch.out_blue);
               check_field("out_green", want.green, rsp_ch.out_green);
               check_field("out_red", want.red, rsp_ch.out_red);
               check_field("frame_end", want.frame_end, rsp_ch.frame_end);
               results_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, MAX_GAP) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      pixel_req_type item;
      req_ch.valid    = 1'b0;
      req_ch.mode     = MODE_PIXEL;
      req_ch.in_blue  = '0;
      req_ch.in_green = '0;
      req_ch.in_red   = '0;
      rsp_ch.ready    = 1'b0;
      csr_we          = 1'b0;
      csr_index       = REG_FRAME_WIDTH;
      csr_wdata       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // flush at stream start, one 4x3 frame of extremes, then drain the tail and one more
      set_frame(4, 3);
      pixel_stream.push_back(flush_item());
      foreach (OPENING_FRAME[i]) begin
         item.mode  = MODE_PIXEL;
         item.blue  = OPENING_FRAME[i][CHAN_W*0 +: CHAN_W];
         item.green = OPENING_FRAME[i][CHAN_W*1 +: CHAN_W];
         item.red   = OPENING_FRAME[i][CHAN_W*2 +: CHAN_W];
         pixel_stream.push_back(item);
      end
      repeat (6) pixel_stream.push_back(flush_item());

      for (int p = 0; p < N_PHASES; p++) begin
         set_frame(PH_WIDTH[p], PH_HEIGHT[p]);
         if (p == 4) begin
            queue_pixels(PHASE_PIXELS / 2);
            wait_drained();
            write_csr(REG_SPARE_A, $urandom_range(0, 2047));
            write_csr(REG_SPARE_B, $urandom_range(0, 2047));
            queue_pixels(PHASE_PIXELS - PHASE_PIXELS / 2);
         end else begin
            queue_pixels(PHASE_PIXELS);
         end
      end

      set_frame(12, 3);
      queue_pixels(36);

      set_frame(8, 3);
      calm = 1'b1;
      queue_pixels(48);
      repeat (9) pixel_stream.push_back(flush_item());
      wait_drained();

      $display("Run covered %0d pixel and %0d flush transactions over %0d frame settings,",
               pixels_sent, flushes_sent, settings_used);
      $display("with %0d blurred pixels checked against the predictor.", results_checked);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/gb3_pkg.sv
rtl/gb3_if.sv
rtl/gb3_ram.sv
rtl/gaussian_blur_3x3_rgb_top.sv
rtl/gb3_checker.sv
dv/testbench.sv
